[hw/rtl/nea_pkg.sv]
// Shared types, widths and index tables for the normal equation accumulator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nea_pkg;

    localparam int DOF      = 6;
    localparam int TRI_N    = 21;
    localparam int JAC_W    = 24;
    localparam int PROD_W   = 2 * JAC_W;
    localparam int SUM_W    = 64;
    localparam int ROW_W    = 3;
    localparam int TRI_W    = 5;

    localparam logic [ROW_W-1:0] ROW_FIRST = 3'd0;
    localparam logic [ROW_W-1:0] ROW_FINAL = 3'd5;

    typedef logic signed [JAC_W-1:0]  t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // Upper triangle, row major: entry for (row, col) of the symmetric sum.
    localparam logic [TRI_W-1:0] TRI_INDEX [DOF][DOF] = '{
        '{5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5 },
        '{5'd1,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10},
        '{5'd2,  5'd7,  5'd11, 5'd12, 5'd13, 5'd14},
        '{5'd3,  5'd8,  5'd12, 5'd15, 5'd16, 5'd17},
        '{5'd4,  5'd9,  5'd13, 5'd16, 5'd18, 5'd19},
        '{5'd5,  5'd10, 5'd14, 5'd17, 5'd19, 5'd20}
    };

    // Jacobian element pair that feeds each triangle entry.
    localparam logic [ROW_W-1:0] TRI_ROW [TRI_N] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3,
        3'd4, 3'd4,
        3'd5
    };
    localparam logic [ROW_W-1:0] TRI_COL [TRI_N] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd2, 3'd3, 3'd4, 3'd5,
        3'd3, 3'd4, 3'd5,
        3'd4, 3'd5,
        3'd5
    };

endpackage

[hw/rtl/nea_lane.sv]
// One accumulation lane: registered 24x24 product, then saturating 64-bit add.
// Depends on nea_pkg.
`timescale 1ns / 1ps

module nea_lane
    import nea_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_elem i_a,
    input  t_elem i_b,
    input  logic  i_acc_en,
    input  logic  i_acc_clear,
    output t_sum  o_next
);

    t_prod r_prod;
    t_sum  r_acc;
    logic signed [SUM_W:0] n_wide;
    t_sum  n_acc;

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_prod <= i_a * i_b;
        end
    end

    always_comb begin
        n_wide = {r_acc[SUM_W-1], r_acc}
               + {{(SUM_W + 1 - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        if (n_wide[SUM_W] != n_wide[SUM_W-1]) begin
            // clamp towards the sign of the true sum
            n_acc = n_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_acc = n_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_acc_en) begin
            r_acc <= i_acc_clear ? '0 : n_acc;
        end
    end

    assign o_next = n_acc;

endmodule

[hw/rtl/nea_merge.sv]
// Result bank: captures the lane sums on a final term and shifts out six rows.
// Depends on nea_pkg.
`timescale 1ns / 1ps

module nea_merge
    import nea_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_sum             i_tri [TRI_N],
    input  t_sum             i_grad [DOF],
    input  t_sum             i_square,
    output logic             o_busy,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ROW_W-1:0] o_row_index,
    output t_sum             o_cols [DOF],
    output t_sum             o_gradient_entry,
    output logic [SUM_W-2:0] o_square_total,
    output logic             o_row_last
);

    logic             r_busy;
    logic [ROW_W-1:0] r_row;
    t_sum             r_mat [DOF][DOF];
    t_sum             r_grad [DOF];
    t_sum             r_square;
    logic             n_xfer;

    assign n_xfer = r_busy && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_FIRST;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_row  <= ROW_FIRST;
        end else if (n_xfer) begin
            if (r_row == ROW_FINAL) begin
                r_busy <= 1'b0;
                r_row  <= ROW_FIRST;
            end else begin
                r_row  <= r_row + 3'd1;
            end
        end
    end

    // Rows move up by one per transfer so the output always reads row slot 0.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int r = 0; r < DOF; r++) begin
                for (int c = 0; c < DOF; c++) begin
                    r_mat[r][c] <= i_tri[TRI_INDEX[r][c]];
                end
                r_grad[r] <= i_grad[r];
            end
            r_square <= i_square;
        end else if (n_xfer) begin
            for (int r = 0; r < DOF - 1; r++) begin
                r_mat[r]  <= r_mat[r+1];
                r_grad[r] <= r_grad[r+1];
            end
        end
    end

    assign o_busy           = r_busy;
    assign o_valid          = r_busy;
    assign o_row_index      = r_row;
    assign o_cols           = r_mat[0];
    assign o_gradient_entry = r_grad[0];
    assign o_square_total   = r_square[SUM_W-2:0];
    assign o_row_last       = (r_row == ROW_FINAL);

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_busy)
        else $error("result bank reloaded before all rows were sent");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_row <= ROW_FINAL))
        else $error("row counter out of range");

    a_last_row_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_xfer && r_row == ROW_FINAL && !i_load) |=> !r_busy)
        else $error("bank still busy after final row transfer");

    a_load_starts_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_busy && r_row == ROW_FIRST))
        else $error("load did not start at row 0");

endmodule

[hw/rtl/normal_equation_accumulator_core.sv]
// Normal equation accumulator, top level: 28 multiply-accumulate lanes and
// the result bank. Depends on nea_pkg, nea_lane and nea_merge.
`timescale 1ns / 1ps

// Takes one residual term per cycle. Each term passes through a registered
// multiplier and then a saturating 64-bit adder in each of 28 lanes (21
// triangle entries, 6 gradient entries, 1 square sum), so a term's products
// reach the sums at the edge after its transfer. The first row of a batch is
// offered when the bank holds its sums. A term marked final has its sums
// copied into a result bank and the lanes restart from zero; the bank then
// sends six rows, one per output transfer, while new terms keep flowing in.
// The input stalls only a final term that arrives while the bank still holds
// an earlier batch (six output transfers) or while another final term is in
// the multiplier stage.

module normal_equation_accumulator_core
    import nea_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [JAC_W-1:0] i_jac_0,
    input  logic signed [JAC_W-1:0] i_jac_1,
    input  logic signed [JAC_W-1:0] i_jac_2,
    input  logic signed [JAC_W-1:0] i_jac_3,
    input  logic signed [JAC_W-1:0] i_jac_4,
    input  logic signed [JAC_W-1:0] i_jac_5,
    input  logic signed [JAC_W-1:0] i_residual,
    input  logic                    i_final_term,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ROW_W-1:0]        o_row_index,
    output logic signed [SUM_W-1:0] o_col_0,
    output logic signed [SUM_W-1:0] o_col_1,
    output logic signed [SUM_W-1:0] o_col_2,
    output logic signed [SUM_W-1:0] o_col_3,
    output logic signed [SUM_W-1:0] o_col_4,
    output logic signed [SUM_W-1:0] o_col_5,
    output logic signed [SUM_W-1:0] o_gradient_entry,
    output logic [SUM_W-2:0]        o_square_total,
    output logic                    o_row_last
);

    t_elem n_jac [DOF];
    t_sum  n_tri [TRI_N];
    t_sum  n_grad [DOF];
    t_sum  n_square;
    t_sum  n_cols [DOF];
    logic  n_take;
    logic  n_busy;
    logic  r_v1;
    logic  r_f1;

    assign n_jac[0] = i_jac_0;
    assign n_jac[1] = i_jac_1;
    assign n_jac[2] = i_jac_2;
    assign n_jac[3] = i_jac_3;
    assign n_jac[4] = i_jac_4;
    assign n_jac[5] = i_jac_5;

    assign o_stall = i_final_term && (n_busy || (r_v1 && r_f1));
    assign n_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_f1 <= 1'b0;
        end else begin
            r_v1 <= n_take;
            r_f1 <= n_take && i_final_term;
        end
    end

    for (genvar k = 0; k < TRI_N; k++) begin : g_tri
        nea_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_take      (n_take),
            .i_a         (n_jac[TRI_ROW[k]]),
            .i_b         (n_jac[TRI_COL[k]]),
            .i_acc_en    (r_v1),
            .i_acc_clear (r_f1),
            .o_next      (n_tri[k])
        );
    end

    for (genvar g = 0; g < DOF; g++) begin : g_grad
        nea_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_take      (n_take),
            .i_a         (n_jac[g]),
            .i_b         (i_residual),
            .i_acc_en    (r_v1),
            .i_acc_clear (r_f1),
            .o_next      (n_grad[g])
        );
    end

    // r*r is never negative, so the shared clamp only ever hits the top limit
    nea_lane u_square (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (n_take),
        .i_a         (i_residual),
        .i_b         (i_residual),
        .i_acc_en    (r_v1),
        .i_acc_clear (r_f1),
        .o_next      (n_square)
    );

    nea_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (r_v1 && r_f1),
        .i_tri            (n_tri),
        .i_grad           (n_grad),
        .i_square         (n_square),
        .o_busy           (n_busy),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_row_index      (o_row_index),
        .o_cols           (n_cols),
        .o_gradient_entry (o_gradient_entry),
        .o_square_total   (o_square_total),
        .o_row_last       (o_row_last)
    );

    assign o_col_0 = n_cols[0];
    assign o_col_1 = n_cols[1];
    assign o_col_2 = n_cols[2];
    assign o_col_3 = n_cols[3];
    assign o_col_4 = n_cols[4];
    assign o_col_5 = n_cols[5];

endmodule
